// File: design/window_trend_statistics_top_assert.svh
// assertion macros used by the checker file
`ifndef WINDOW_TREND_STATISTICS_TOP_ASSERT_SVH
`define WINDOW_TREND_STATISTICS_TOP_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define WTS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("window trend check failed");

// a signal holds while a word is stalled
`define WTS_HOLD(lbl, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (vld && !rdy) |=> $stable(sig)) \
	else $error("stalled word changed");

`endif

// File: design/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// shared widths, defaults and helpers of the window trend statistics block
// ----------------------------------------------------------------------------
package wts_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CFG_W           = 7;
	localparam int OUT_W           = 16;
	localparam int EVO_W           = 32;
	localparam int PCT_SCALE       = 100;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd7;

	// clamp an unsigned value to the 16 bit output range
	function automatic logic [OUT_W-1:0] sat_u16(input logic [63:0] v);
		logic [OUT_W-1:0] r;
		if (v > 64'd65535) r = '1;
		else r = v[OUT_W-1:0];
		return r;
	endfunction

endpackage

// File: design/window_trend_statistics_top.sv
// The time from input word to result word is set by the ring read loop, the serial squarer,
// the serial square root and the serial dividers. One word is in work at a time; the next
// can be taken as soon as the result is registered, even while that result waits.
// Reset clears control, counters and tendency flags; the sample ring is not cleared.
// ----------------------------------------------------------------------------
// window_trend_statistics_top
// sliding window rise average, relative evolution, deviation and tendency switches
// ----------------------------------------------------------------------------
module window_trend_statistics_top #(
	parameter int WINDOW_MAX  = wts_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = wts_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wts_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            rise_valid,
	output logic [wts_pkg::OUT_W-1:0]       rise_average,
	output logic                            evolution_valid,
	output logic signed [wts_pkg::EVO_W-1:0] evolution,
	output logic                            deviation_valid,
	output logic [wts_pkg::OUT_W-1:0]       deviation,
	output logic                            switched,
	output logic [wts_pkg::OUT_W-1:0]       switch_total
);

	localparam int SB   = SAMPLE_BITS;
	localparam int RD   = WINDOW_MAX + 1;
	localparam int AWR  = $clog2(RD);
	localparam int WB   = $clog2(WINDOW_MAX + 1);
	localparam int CW   = WB + 1;
	localparam int SW   = $clog2(RD + 1);
	localparam int SUMW = SB + WB;
	localparam int RNW  = SUMW + 1;
	localparam int AW   = SB + WB;
	localparam int S2W  = 2 * SB + WB;
	localparam int QW   = 2 * AW;
	localparam int SQW  = QW + 2;
	localparam int RW   = SQW / 2;
	localparam int DNW  = RW + 1;
	localparam int DDW  = WB + 1;
	localparam int ENW  = SB + 16;
	localparam int EDW  = SB + 1;
	localparam int SQCW = $clog2(AW + 1);
	localparam int EVSCALE = 2 * wts_pkg::PCT_SCALE * wts_pkg::PCT_SCALE;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_ACC  = 8'b0000_0010,
		S_PREP = 8'b0000_0100,
		S_SQR  = 8'b0000_1000,
		S_QV   = 8'b0001_0000,
		S_ROOT = 8'b0010_0000,
		S_DDIV = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [wts_pkg::CFG_W-1:0] wlen_q;
	logic [AWR-1:0]  head_q;
	logic [AWR-1:0]  rd_addr_q;
	logic [SW-1:0]   seen_q;
	logic [WB-1:0]   p_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   kd_q;
	logic            dv_q;
	logic signed [SB-1:0] ring_q [RD];
	logic signed [SB-1:0] rdata_q;
	logic signed [SB-1:0] x_q;
	logic signed [SB-1:0] prev_q;
	logic signed [SB-1:0] old_q;
	logic [SUMW-1:0] sum_q;
	logic signed [AW-1:0] s1_q;
	logic [S2W-1:0]  s2_q;
	logic [QW-1:0]   mc_q;
	logic [AW-1:0]   mp_q;
	logic [QW-1:0]   sq_q;
	logic [SQCW-1:0] sq_cnt_q;
	logic            tknown_q;
	logic            tup_q;
	logic            lup_q;
	logic [wts_pkg::OUT_W-1:0] swcnt_q;

	logic            out_valid_q;
	logic            rise_v_q;
	logic [wts_pkg::OUT_W-1:0] rise_a_q;
	logic            evo_v_q;
	logic signed [wts_pkg::EVO_W-1:0] evo_q;
	logic            dev_v_q;
	logic [wts_pkg::OUT_W-1:0] dev_q;
	logic            sw_q;

	logic            acc_in;
	logic            load_out;
	logic [WB-1:0]   p_cfg;
	logic signed [2*SB-1:0] vsq;
	logic signed [SB:0] dstep;
	logic signed [SB:0] diff;
	logic [SB:0]     mag_diff;
	logic [SB-1:0]   mag_old;
	logic [AW-1:0]   mag_s1;
	logic [QW-1:0]   qv;

	logic            rise_start, evo_start, root_start, dev_start;
	logic            rise_busy, evo_busy, root_busy, dev_busy;
	logic [RNW-1:0]  rise_quo;
	logic [ENW-1:0]  evo_quo;
	logic [RW-1:0]   root_val;
	logic [DNW-1:0]  dev_quo;

	// result fields of the finishing word
	logic            fin_rise_v, fin_old_nz, fin_neg, fin_lup, fin_tup, fin_sw;
	logic signed [wts_pkg::EVO_W-1:0] fin_evo;

	assign acc_in   = in_valid && (state_q == S_IDLE);
	assign load_out = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign p_cfg    = (int'(wlen_q) > WINDOW_MAX) ? WB'(WINDOW_MAX) : WB'(wlen_q);

	// per sample arithmetic of the accumulation loop
	always_comb begin
		vsq      = rdata_q * rdata_q;
		dstep    = (SB + 1)'(prev_q) - (SB + 1)'(rdata_q);
		diff     = (SB + 1)'(x_q) - (SB + 1)'(old_q);
		mag_diff = diff[SB] ? (SB + 1)'(-diff) : diff;
		mag_old  = old_q[SB-1] ? SB'(-old_q) : old_q;
		mag_s1   = s1_q[AW-1] ? AW'(-s1_q) : s1_q;
		qv       = QW'(p_q) * QW'(s2_q) - sq_q;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wlen_q <= wts_pkg::WINDOW_RESET;
		else if (cfg_we) wlen_q <= cfg_wdata;
	end

	// sample ring, write on accept and one registered read a cycle
	always_ff @(posedge clk) begin
		if (acc_in) ring_q[head_q] <= sample;
		rdata_q <= ring_q[rd_addr_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			seen_q   <= '0;
			cnt_q    <= '0;
			dv_q     <= 1'b0;
			sq_cnt_q <= '0;
		end else begin
			dv_q <= (state_q == S_ACC) && (cnt_q <= CW'(p_q));
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						head_q <= (head_q == AWR'(RD - 1)) ? '0 : head_q + 1'b1;
						if (seen_q < SW'(RD)) seen_q <= seen_q + 1'b1;
						cnt_q   <= '0;
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (cnt_q <= CW'(p_q)) cnt_q <= cnt_q + 1'b1;
					if (dv_q && kd_q == CW'(p_q)) state_q <= S_PREP;
				end
				S_PREP: begin
					sq_cnt_q <= '0;
					state_q  <= S_SQR;
				end
				S_SQR: begin
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == SQCW'(AW - 1)) state_q <= S_QV;
				end
				S_QV: state_q <= S_ROOT;
				S_ROOT: begin
					if (!root_busy) state_q <= S_DDIV;
				end
				S_DDIV: begin
					if (!dev_busy && !evo_busy && !rise_busy) state_q <= S_FIN;
				end
				S_FIN: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// read address walks back from the newest sample
	always_ff @(posedge clk) begin
		if (acc_in) rd_addr_q <= head_q;
		else if (state_q == S_ACC)
			rd_addr_q <= (rd_addr_q == '0) ? AWR'(RD - 1) : rd_addr_q - 1'b1;
		kd_q <= cnt_q;
	end

	// window sums and captured samples
	always_ff @(posedge clk) begin
		if (acc_in) begin
			x_q   <= sample;
			p_q   <= p_cfg;
			sum_q <= '0;
			s1_q  <= '0;
			s2_q  <= '0;
		end else if (dv_q) begin
			if (kd_q < CW'(p_q)) begin
				s1_q <= s1_q + AW'(rdata_q);
				s2_q <= s2_q + S2W'($unsigned(vsq));
			end
			if (kd_q != '0 && !dstep[SB]) sum_q <= sum_q + SUMW'(dstep[SB-1:0]);
			prev_q <= rdata_q;
			if (kd_q == CW'(p_q)) old_q <= rdata_q;
		end
	end

	// serial square of the window sum, one multiplier bit a cycle
	always_ff @(posedge clk) begin
		if (state_q == S_PREP) begin
			mc_q <= QW'(mag_s1);
			mp_q <= mag_s1;
			sq_q <= '0;
		end else if (state_q == S_SQR) begin
			if (mp_q[0]) sq_q <= sq_q + mc_q;
			mc_q <= {mc_q[QW-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[AW-1:1]};
		end
	end

	assign rise_start = (state_q == S_PREP);
	assign evo_start  = (state_q == S_PREP);
	assign root_start = (state_q == S_QV);
	assign dev_start  = (state_q == S_ROOT) && !root_busy;

	// rounded rise average
	wts_sdiv #(.NW(RNW), .DW(WB)) u_rise_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rise_start),
		.num    (RNW'(sum_q) + RNW'(p_q >> 1)),
		.den    (p_q),
		.busy   (rise_busy),
		.quo    (rise_quo)
	);

	// rounded relative evolution magnitude
	wts_sdiv #(.NW(ENW), .DW(EDW)) u_evo_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (evo_start),
		.num    (ENW'(mag_diff) * ENW'(EVSCALE) + ENW'(mag_old)),
		.den    ({mag_old, 1'b0}),
		.busy   (evo_busy),
		.quo    (evo_quo)
	);

	// root of four times the scaled variance
	wts_isqrt #(.W(SQW)) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.rad    ({qv, 2'b00}),
		.busy   (root_busy),
		.root   (root_val)
	);

	// rounded deviation
	wts_sdiv #(.NW(DNW), .DW(DDW)) u_dev_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dev_start),
		.num    (DNW'(root_val) + DNW'(p_q)),
		.den    ({p_q, 1'b0}),
		.busy   (dev_busy),
		.quo    (dev_quo)
	);

	// tendency and evolution of the finishing word
	always_comb begin
		fin_rise_v = SW'(p_q) < seen_q;
		fin_old_nz = old_q != '0;
		fin_neg    = (diff[SB] != old_q[SB-1]) && (diff != '0);
		fin_evo    = '0;
		if (fin_rise_v && fin_old_nz) begin
			if (fin_neg) begin
				if (64'(evo_quo) > 64'd2147483648) fin_evo = {1'b1, {(wts_pkg::EVO_W-1){1'b0}}};
				else fin_evo = -wts_pkg::EVO_W'(evo_quo);
			end else begin
				if (64'(evo_quo) > 64'd2147483647) fin_evo = {1'b0, {(wts_pkg::EVO_W-1){1'b1}}};
				else fin_evo = wts_pkg::EVO_W'(evo_quo);
			end
		end
		fin_lup = lup_q;
		if (fin_rise_v) fin_lup = fin_old_nz ? !fin_neg : 1'b1;
		fin_tup = (fin_rise_v && !tknown_q) ? fin_lup : tup_q;
		fin_sw  = fin_lup != fin_tup;
	end

	// tendency state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tknown_q <= 1'b0;
			tup_q    <= 1'b0;
			lup_q    <= 1'b0;
			swcnt_q  <= '0;
		end else if (load_out) begin
			lup_q <= fin_lup;
			tup_q <= fin_lup;
			if (fin_rise_v) tknown_q <= 1'b1;
			if (fin_sw && swcnt_q != '1) swcnt_q <= swcnt_q + 1'b1;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_out) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rise_v_q <= fin_rise_v;
			rise_a_q <= (fin_rise_v && p_q != '0) ? wts_pkg::sat_u16(64'(rise_quo)) : '0;
			evo_v_q  <= fin_rise_v;
			evo_q    <= fin_evo;
			dev_v_q  <= SW'(p_q) <= seen_q;
			dev_q    <= (SW'(p_q) <= seen_q && p_q != '0) ?
			            wts_pkg::sat_u16(64'(dev_quo)) : '0;
			sw_q     <= fin_sw;
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign rise_valid      = rise_v_q;
	assign rise_average    = rise_a_q;
	assign evolution_valid = evo_v_q;
	assign evolution       = evo_q;
	assign deviation_valid = dev_v_q;
	assign deviation       = dev_q;
	assign switched        = sw_q;
	assign switch_total    = swcnt_q;

endmodule

// File: design/wts_sdiv.sv
// ----------------------------------------------------------------------------
// wts_sdiv
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wts_sdiv #(
	parameter int NW = 32,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [DW:0]     shifted;
	logic            fits;

	// trial subtract of the next partial remainder
	always_comb begin
		shifted = {rem_q, quo_q[NW-1]};
		fits    = shifted >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(NW - 1)) busy_q <= 1'b0;
		end
	end

	// datapath: numerator shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (fits) rem_q <= DW'(shifted - {1'b0, den_q});
			else rem_q <= shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// File: design/wts_isqrt.sv
// ----------------------------------------------------------------------------
// wts_isqrt
// integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module wts_isqrt #(
	parameter int W = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   rad,
	output logic           busy,
	output logic [W/2-1:0] root
);

	localparam int RWW  = W / 2;
	localparam int CNTW = $clog2(RWW + 1);

	logic [W-1:0]     rad_q;
	logic [RWW+1:0]   rem_q;
	logic [RWW-1:0]   root_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q;
	logic [RWW+3:0]   sh;
	logic [RWW+3:0]   trial;
	logic             fits;

	// bring down the next digit pair and try root*4+1
	always_comb begin
		sh    = {rem_q, rad_q[W-1:W-2]};
		trial = (RWW + 4)'({root_q, 2'b01});
		fits  = sh >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(RWW - 1)) busy_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[W-3:0], 2'b00};
			if (fits) rem_q <= (RWW + 2)'(sh - trial);
			else rem_q <= sh[RWW+1:0];
			root_q <= {root_q[RWW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// File: design/wts_checker.sv
// ----------------------------------------------------------------------------
// wts_checker
// port level checks of the window trend statistics block
// ----------------------------------------------------------------------------
`include "window_trend_statistics_top_assert.svh"

module wts_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic                             rise_valid,
	input logic [wts_pkg::OUT_W-1:0]        rise_average,
	input logic                             evolution_valid,
	input logic signed [wts_pkg::EVO_W-1:0] evolution,
	input logic                             deviation_valid,
	input logic [wts_pkg::OUT_W-1:0]        deviation,
	input logic                             switched,
	input logic [wts_pkg::OUT_W-1:0]        switch_total
);

	// a stalled result word stays up
	`WTS_HOLD(a_out_hold, out_valid, out_ready, out_valid)

	// rise and evolution share one validity rule
	`WTS_ASSERT(a_valid_pair, out_valid |-> rise_valid == evolution_valid)

	// invalid figures read as zero
	`WTS_ASSERT(a_zero_invalid, (out_valid && !rise_valid) |-> (rise_average == '0 && evolution == '0))

	// a reported switch has been counted
	`WTS_ASSERT(a_switch_count, (out_valid && switched) |-> switch_total != '0)

endmodule

bind window_trend_statistics_top wts_checker u_wts_checker (.*);
